/* hdl/afaa_pkg.sv */
// Shared constants, types and the microcode table of the aligned first-fit allocator.
// No dependencies; used by afaa_seq, afaa_dp and the top level.
package afaa_pkg;

	localparam int SLOTS    = 256;
	localparam int MAX_SIZE = 16;

	localparam int IDX_W  = $clog2(SLOTS);
	localparam int PTR_W  = IDX_W + 1;
	localparam int SUM_W  = PTR_W + 1;
	localparam int SZ_W   = 5;
	localparam int CNT_W  = $clog2(MAX_SIZE + 1);
	localparam int TAG_W  = 16;
	localparam int OFS_W  = 8;
	localparam int HW_W   = 9;
	localparam int STEP_W = 4;

	localparam logic OP_CLEAR = 1'b0;
	localparam logic OP_ALLOC = 1'b1;

	// program steps
	localparam logic [STEP_W-1:0] ST_IDLE    = 4'd0;
	localparam logic [STEP_W-1:0] ST_DECODE  = 4'd1;
	localparam logic [STEP_W-1:0] ST_CHECK   = 4'd2;
	localparam logic [STEP_W-1:0] ST_SCAN    = 4'd3;
	localparam logic [STEP_W-1:0] ST_RESOLVE = 4'd4;
	localparam logic [STEP_W-1:0] ST_MARK    = 4'd5;
	localparam logic [STEP_W-1:0] ST_DONE    = 4'd6;
	localparam logic [STEP_W-1:0] ST_FAIL    = 4'd7;
	localparam logic [STEP_W-1:0] ST_CLEAR   = 4'd8;
	localparam logic [STEP_W-1:0] ST_CLRDONE = 4'd9;
	localparam logic [STEP_W-1:0] ST_RSTCLR  = 4'd10;

	// jump conditions
	localparam logic [2:0] C_ALWAYS  = 3'd0;
	localparam logic [2:0] C_START   = 3'd1;
	localparam logic [2:0] C_ALLOC   = 3'd2;
	localparam logic [2:0] C_BAD     = 3'd3;
	localparam logic [2:0] C_EXIT    = 3'd4;
	localparam logic [2:0] C_OVER    = 3'd5;
	localparam logic [2:0] C_LAST    = 3'd6;
	localparam logic [2:0] C_CLRLAST = 3'd7;

	// datapath operations
	localparam logic [2:0] DP_NOP      = 3'd0;
	localparam logic [2:0] DP_LOAD     = 3'd1;
	localparam logic [2:0] DP_SCANINIT = 3'd2;
	localparam logic [2:0] DP_SCAN     = 3'd3;
	localparam logic [2:0] DP_MARKINIT = 3'd4;
	localparam logic [2:0] DP_MARK     = 3'd5;
	localparam logic [2:0] DP_HMARK    = 3'd6;
	localparam logic [2:0] DP_CLEAR    = 3'd7;

	typedef struct packed {
		logic [2:0]        cond;
		logic [STEP_W-1:0] jt;
		logic [STEP_W-1:0] jf;
		logic [2:0]        op;
		logic              emit;
		logic              efail;
	} uword_t;

	typedef struct packed {
		logic alloc;
		logic bad;
		logic over;
		logic exit_scan;
		logic last;
		logic clr_last;
	} flags_t;

	function automatic uword_t ucode(input logic [STEP_W-1:0] step);
		uword_t w;
		w = '{cond: C_ALWAYS, jt: ST_IDLE, jf: ST_IDLE, op: DP_NOP, emit: 1'b0, efail: 1'b0};
		unique case (step)
			ST_IDLE:    w = '{C_START,   ST_DECODE,  ST_IDLE,   DP_LOAD,     1'b0, 1'b0};
			ST_DECODE:  w = '{C_ALLOC,   ST_CHECK,   ST_CLEAR,  DP_SCANINIT, 1'b0, 1'b0};
			ST_CHECK:   w = '{C_BAD,     ST_FAIL,    ST_SCAN,   DP_SCANINIT, 1'b0, 1'b0};
			ST_SCAN:    w = '{C_EXIT,    ST_RESOLVE, ST_SCAN,   DP_SCAN,     1'b0, 1'b0};
			ST_RESOLVE: w = '{C_OVER,    ST_FAIL,    ST_MARK,   DP_MARKINIT, 1'b0, 1'b0};
			ST_MARK:    w = '{C_LAST,    ST_DONE,    ST_MARK,   DP_MARK,     1'b0, 1'b0};
			ST_DONE:    w = '{C_ALWAYS,  ST_IDLE,    ST_IDLE,   DP_HMARK,    1'b1, 1'b0};
			ST_FAIL:    w = '{C_ALWAYS,  ST_IDLE,    ST_IDLE,   DP_NOP,      1'b1, 1'b1};
			ST_CLEAR:   w = '{C_CLRLAST, ST_CLRDONE, ST_CLEAR,  DP_CLEAR,    1'b0, 1'b0};
			ST_CLRDONE: w = '{C_ALWAYS,  ST_IDLE,    ST_IDLE,   DP_NOP,      1'b1, 1'b0};
			ST_RSTCLR:  w = '{C_CLRLAST, ST_IDLE,    ST_RSTCLR, DP_CLEAR,    1'b0, 1'b0};
			default:    w = '{C_ALWAYS,  ST_IDLE,    ST_IDLE,   DP_NOP,      1'b0, 1'b0};
		endcase
		return w;
	endfunction

endpackage

/* hdl/afaa_seq.sv */
// Microcode sequencer: step counter, control store lookup and conditional jumps.
// Depends on afaa_pkg.
module afaa_seq
	import afaa_pkg::*;
(
	input  logic   clk,
	input  logic   arst_n,
	input  logic   start,
	input  flags_t flags,
	output uword_t ctl,
	output logic   busy
);

	logic [STEP_W-1:0] step_q;
	logic              take;

	assign ctl  = ucode(step_q);
	assign busy = (step_q != ST_IDLE);

	always_comb begin
		unique case (ctl.cond)
			C_ALWAYS:  take = 1'b1;
			C_START:   take = start;
			C_ALLOC:   take = flags.alloc;
			C_BAD:     take = flags.bad;
			C_EXIT:    take = flags.exit_scan;
			C_OVER:    take = flags.over;
			C_LAST:    take = flags.last;
			C_CLRLAST: take = flags.clr_last;
			default:   take = 1'b1;
		endcase
	end

	// reset lands in the clearing pass of the occupancy RAM
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q <= ST_RSTCLR;
		end else begin
			step_q <= take ? ctl.jt : ctl.jf;
		end
	end

endmodule

/* hdl/afaa_dp.sv */
// Allocator datapath: slot occupancy RAM, scan cursor, high-water mark, result registers.
// Depends on afaa_pkg; driven by the control word from afaa_seq.
module afaa_dp
	import afaa_pkg::*;
(
	input  logic             clk,
	input  logic             arst_n,
	input  uword_t           ctl,
	input  logic             opcode,
	input  logic [SZ_W-1:0]  var_size,
	input  logic [TAG_W-1:0] var_tag,
	output flags_t           flags,
	output logic             done,
	output logic [OFS_W-1:0] slot_offset,
	output logic [TAG_W-1:0] tag_out,
	output logic [HW_W-1:0]  high_water,
	output logic             failed
);

	logic              op_q;
	logic [SZ_W-1:0]   sz_q;
	logic [TAG_W-1:0]  tag_q;
	logic [PTR_W-1:0]  start_q;
	logic [PTR_W-1:0]  pos_q;
	logic [CNT_W-1:0]  cnt_q;
	logic [PTR_W-1:0]  hm_q;
	logic              slot_mem [SLOTS];
	logic              rd_s1;
	logic              vld_s1;

	logic              done_q;
	logic              failed_q;
	logic [OFS_W-1:0]  ofs_q;
	logic [TAG_W-1:0]  tago_q;
	logic [HW_W-1:0]   hw_q;

	logic [SUM_W-1:0]  end_sum;
	logic              over;
	logic              slot_taken;
	logic              last;
	logic              found;
	logic              bad;
	logic              clr_last;
	logic              mem_we;
	logic              mem_wd;
	logic [PTR_W-1:0]  end_ptr;
	logic [PTR_W-1:0]  hm_new;

	assign end_sum    = SUM_W'(start_q) + SUM_W'(sz_q);
	assign end_ptr    = PTR_W'(end_sum);
	assign over       = end_sum > SUM_W'(SLOTS);
	// rd_s1 holds slot start_q + cnt_q when vld_s1 is set
	assign slot_taken = vld_s1 && rd_s1;
	assign last       = (cnt_q == CNT_W'(sz_q - SZ_W'(1)));
	assign found      = vld_s1 && !rd_s1 && last;
	assign bad        = (sz_q == '0) || (int'(sz_q) > MAX_SIZE) || (int'(sz_q) > SLOTS);
	assign hm_new     = (SUM_W'(hm_q) < end_sum) ? end_ptr : hm_q;
	assign clr_last   = (pos_q == PTR_W'(SLOTS - 1));
	assign mem_we     = (ctl.op == DP_MARK) || (ctl.op == DP_CLEAR);
	assign mem_wd     = (ctl.op == DP_MARK);

	assign flags = '{alloc: (op_q == OP_ALLOC), bad: bad, over: over,
		exit_scan: over || found, last: last, clr_last: clr_last};

	// occupancy RAM: one write and one registered read per cycle, both at pos_q
	always_ff @(posedge clk) begin
		if (mem_we) begin
			slot_mem[pos_q[IDX_W-1:0]] <= mem_wd;
		end
		rd_s1 <= slot_mem[pos_q[IDX_W-1:0]];
	end

	// request latch and result registers
	always_ff @(posedge clk) begin
		if (ctl.op == DP_LOAD) begin
			op_q  <= opcode;
			sz_q  <= var_size;
			tag_q <= var_tag;
		end
		if (ctl.emit) begin
			tago_q   <= tag_q;
			failed_q <= ctl.efail;
			if (ctl.efail || op_q == OP_CLEAR) begin
				ofs_q <= '0;
			end else begin
				ofs_q <= OFS_W'(start_q);
			end
			if (op_q == OP_CLEAR) begin
				hw_q <= '0;
			end else if (ctl.efail) begin
				hw_q <= HW_W'(hm_q);
			end else begin
				hw_q <= HW_W'(hm_new);
			end
		end
	end

	// scan cursor and high-water mark
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start_q <= '0;
			pos_q   <= '0;
			cnt_q   <= '0;
			vld_s1  <= 1'b0;
			hm_q    <= '0;
			done_q  <= 1'b0;
		end else begin
			done_q <= ctl.emit;
			unique case (ctl.op)
				DP_SCANINIT: begin
					start_q <= '0;
					pos_q   <= '0;
					cnt_q   <= '0;
					vld_s1  <= 1'b0;
				end
				DP_SCAN: begin
					if (!(over || found)) begin
						if (slot_taken) begin
							// conflict: jump to the next aligned start; the read in
							// flight is already that slot when the conflict was the
							// run's last slot
							start_q <= end_ptr;
							pos_q   <= last ? end_ptr + PTR_W'(1) : end_ptr;
							cnt_q   <= '0;
							vld_s1  <= last;
						end else begin
							pos_q  <= pos_q + PTR_W'(1);
							vld_s1 <= 1'b1;
							if (vld_s1) begin
								cnt_q <= cnt_q + CNT_W'(1);
							end
						end
					end
				end
				DP_MARKINIT: begin
					pos_q <= start_q;
					cnt_q <= '0;
				end
				DP_MARK: begin
					pos_q <= pos_q + PTR_W'(1);
					cnt_q <= cnt_q + CNT_W'(1);
				end
				DP_HMARK: hm_q <= hm_new;
				DP_CLEAR: begin
					pos_q <= pos_q + PTR_W'(1);
					hm_q  <= '0;
				end
				default: begin
				end
			endcase
		end
	end

	assign done        = done_q;
	assign slot_offset = ofs_q;
	assign tag_out     = tago_q;
	assign high_water  = hw_q;
	assign failed      = failed_q;

endmodule

/* hdl/aligned_first_fit_slot_allocator.sv */
// Aligned first-fit slot allocator, top level.
// Depends on afaa_pkg, afaa_seq and afaa_dp.
//
// Usage: drive opcode, var_size and var_tag with start high; the item is taken
// at a clock edge where start is high and busy is low. opcode 0 clears the
// whole occupancy map and the high-water mark; opcode 1 allocates var_size
// slots at the lowest free start that is a multiple of var_size.
// Each item gives exactly one result: done is high for one cycle with
// slot_offset, tag_out, high_water and failed valid in that cycle. The
// receiver cannot stall; busy is already low while done is shown, so the next
// item may be taken in that cycle.
// A bad size goes straight from the check to a failed result. A clear zeroes
// the occupancy RAM one slot per cycle.
// An allocation checks one slot per cycle through the registered RAM read,
// with a bubble at the start and after a conflict short of a run's end, then
// writes one slot per cycle.
// Reset (arst_n low) clears the high-water mark at once and starts a pass that
// zeroes the map with busy high; no item is pending after it.
module aligned_first_fit_slot_allocator
	import afaa_pkg::*;
(
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	output logic             busy,
	input  logic             opcode,
	input  logic [SZ_W-1:0]  var_size,
	input  logic [TAG_W-1:0] var_tag,
	output logic             done,
	output logic [OFS_W-1:0] slot_offset,
	output logic [TAG_W-1:0] tag_out,
	output logic [HW_W-1:0]  high_water,
	output logic             failed
);

	uword_t ctl;
	flags_t flags;

	afaa_seq u_seq (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.flags  (flags),
		.ctl    (ctl),
		.busy   (busy)
	);

	afaa_dp u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.ctl         (ctl),
		.opcode      (opcode),
		.var_size    (var_size),
		.var_tag     (var_tag),
		.flags       (flags),
		.done        (done),
		.slot_offset (slot_offset),
		.tag_out     (tag_out),
		.high_water  (high_water),
		.failed      (failed)
	);

	// accepted item keeps the sequencer busy in the next cycle
	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |=> busy)
		else $error("sequencer did not leave idle after accept");

	// a result is only shown once the program has returned to idle
	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !busy)
		else $error("result shown while sequencer busy");

	a_fail_offset: assert property (@(posedge clk) disable iff (!arst_n)
		done && failed |-> slot_offset == '0)
		else $error("failed result with nonzero offset");

	// a placed run lies below the high-water mark
	a_hw_cover: assert property (@(posedge clk) disable iff (!arst_n)
		done && !failed && high_water != '0 |-> HW_W'(slot_offset) < high_water)
		else $error("high-water mark below allocated start");

	// the program emits one result per item and never twice in a row
	a_single_done: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !done)
		else $error("back-to-back result strobes");

endmodule

/* sim/slot_alloc_checker.sv */
// Checker for the aligned first-fit slot allocator: watches the item and result ports,
// keeps its own occupancy map and high-water mark, and compares every result in order.
// Depends on afaa_pkg for widths, sizes and opcodes.
module slot_alloc_checker
	import afaa_pkg::*;
(
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  logic             busy,
	input  logic             opcode,
	input  logic [SZ_W-1:0]  var_size,
	input  logic [TAG_W-1:0] var_tag,
	input  logic             done,
	input  logic [OFS_W-1:0] slot_offset,
	input  logic [TAG_W-1:0] tag_out,
	input  logic [HW_W-1:0]  high_water,
	input  logic             failed,
	output int               errors,
	output int               pending
);
	timeunit 1ns;
	timeprecision 1ps;

	typedef struct packed {
		logic [OFS_W-1:0] offset;
		logic [TAG_W-1:0] tag;
		logic [HW_W-1:0]  mark;
		logic             failed;
	} placement_t;

	logic [SLOTS-1:0] occupied = '0;
	int               span_end = 0;
	int               mismatches = 0;
	placement_t       placements_due[$];

	// updates the occupancy map and returns the placement the block should report
	function automatic placement_t place_variable(input logic op, input logic [SZ_W-1:0] sz,
			input logic [TAG_W-1:0] tag);
		placement_t p;
		int len;
		int base;
		int k;
		bit fits;
		bit found;
		len = int'(sz);
		p.offset = '0;
		p.tag = tag;
		p.failed = 1'b0;
		if (op == OP_CLEAR) begin
			occupied = '0;
			span_end = 0;
		end else if (len == 0 || len > MAX_SIZE || len > SLOTS) begin
			p.failed = 1'b1;
		end else begin
			base = 0;
			found = 0;
			while (!found && base + len <= SLOTS) begin
				fits = 1;
				for (k = 0; k < len; k++)
					if (occupied[base + k])
						fits = 0;
				if (fits)
					found = 1;
				else
					base += len;
			end
			if (found) begin
				for (k = 0; k < len; k++)
					occupied[base + k] = 1'b1;
				if (base + len > span_end)
					span_end = base + len;
				p.offset = base[OFS_W-1:0];
			end else begin
				p.failed = 1'b1;
			end
		end
		p.mark = span_end[HW_W-1:0];
		return p;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		placement_t got;
		placement_t want;
		if (!arst_n) begin
			occupied = '0;
			span_end = 0;
			placements_due.delete();
			pending <= 0;
			errors <= mismatches;
		end else begin
			// result first: an item accepted at this edge is never the one reported here
			if (done) begin
				got = '{slot_offset, tag_out, high_water, failed};
				if (placements_due.size() == 0) begin
					mismatches++;
					if (mismatches <= 10)
						$display("%0t: result with no item pending: %s%0d tag=%h hw=%0d fail=%b",
							$realtime, "ofs=", slot_offset, tag_out, high_water, failed);
				end else begin
					want = placements_due.pop_front();
					if (got != want) begin
						mismatches++;
						if (mismatches <= 10)
							$display({"%0t: mismatch exp ofs=%0d tag=%h hw=%0d fail=%b, ",
								"got ofs=%0d tag=%h hw=%0d fail=%b"},
								$realtime, want.offset, want.tag, want.mark, want.failed,
								got.offset, got.tag, got.mark, got.failed);
					end
				end
			end
			if (start && !busy)
				placements_due = {placements_due, place_variable(opcode, var_size, var_tag)};
			pending <= placements_due.size();
			errors <= mismatches;
		end
	end

endmodule

/* sim/tb.sv */
// Top of the allocator testbench: clock, reset, directed and random items, idle gaps,
// watchdog and verdict. Depends on afaa_pkg, slot_alloc_checker and the block's top level.
module tb
	import afaa_pkg::*;
;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int STALL_LIMIT = 4000;
	localparam int RANDOM_ITEMS = 1050;

	logic             clk = 1'b0;
	logic             arst_n;
	logic             start;
	logic             busy;
	logic             opcode;
	logic [SZ_W-1:0]  var_size;
	logic [TAG_W-1:0] var_tag;
	logic             done;
	logic [OFS_W-1:0] slot_offset;
	logic [TAG_W-1:0] tag_out;
	logic [HW_W-1:0]  high_water;
	logic             failed;
	int               errors;
	int               pending;
	int               idle_pct = 6;
	int               quiet_cycles = 0;

	aligned_first_fit_slot_allocator dut (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy),
		.opcode(opcode), .var_size(var_size), .var_tag(var_tag),
		.done(done), .slot_offset(slot_offset), .tag_out(tag_out),
		.high_water(high_water), .failed(failed)
	);

	slot_alloc_checker u_chk (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy),
		.opcode(opcode), .var_size(var_size), .var_tag(var_tag),
		.done(done), .slot_offset(slot_offset), .tag_out(tag_out),
		.high_water(high_water), .failed(failed),
		.errors(errors), .pending(pending)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	// no item taken and no result shown for too long means the block hung
	always @(posedge clk) begin
		if (arst_n) begin
			if ((start && !busy) || done) begin
				quiet_cycles <= 0;
			end else begin
				quiet_cycles <= quiet_cycles + 1;
				if (quiet_cycles >= STALL_LIMIT) begin
					$display("TB_ERROR");
					$finish;
				end
			end
		end
	end

	// start stays high from one item to the next unless a gap is drawn
	task automatic send_item(input logic op, input logic [SZ_W-1:0] sz,
			input logic [TAG_W-1:0] tag);
		while ($urandom_range(99) < idle_pct) begin
			start <= 1'b0;
			@(posedge clk);
		end
		start <= 1'b1;
		opcode <= op;
		var_size <= sz;
		var_tag <= tag;
		// busy only moves at the rising edge; look at it mid-cycle
		@(negedge clk);
		while (busy)
			@(negedge clk);
		@(posedge clk);
	endtask

	// mostly powers of two and plain sizes, a few out-of-range ones
	function automatic logic [SZ_W-1:0] pick_size();
		int roll;
		roll = $urandom_range(99);
		if (roll < 55)
			return SZ_W'(1 << $urandom_range(4));
		else if (roll < 94)
			return SZ_W'($urandom_range(MAX_SIZE, 1));
		else if (roll < 97)
			return '0;
		else
			return SZ_W'($urandom_range(31, MAX_SIZE + 1));
	endfunction

	initial begin
		int n;
		start <= 1'b0;
		opcode <= OP_CLEAR;
		var_size <= '0;
		var_tag <= '0;
		arst_n <= 1'b0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		send_item(OP_CLEAR, 5'd31, 16'h5A5A);
		send_item(OP_ALLOC, 5'd1, 16'h0000);
		send_item(OP_ALLOC, 5'd16, 16'hFFFF);
		send_item(OP_ALLOC, 5'd3, 16'h0003);
		send_item(OP_ALLOC, 5'd0, 16'h00A0);
		send_item(OP_ALLOC, 5'd17, 16'h0011);
		send_item(OP_ALLOC, 5'd31, 16'h001F);
		send_item(OP_CLEAR, 5'd0, 16'hC1EA);
		// fill the whole store, then ask for more: no fit
		for (n = 0; n < SLOTS / MAX_SIZE; n++)
			send_item(OP_ALLOC, SZ_W'(MAX_SIZE), TAG_W'($urandom));
		send_item(OP_ALLOC, SZ_W'(MAX_SIZE), 16'hF00D);
		send_item(OP_ALLOC, 5'd1, 16'hBEEF);
		send_item(OP_CLEAR, 5'd16, 16'h0000);

		for (n = 0; n < RANDOM_ITEMS; n++) begin
			if (n < RANDOM_ITEMS / 3)
				idle_pct = 6;
			else if (n < 2 * RANDOM_ITEMS / 3)
				idle_pct = 72;
			else
				idle_pct = 0;
			if ($urandom_range(99) < 3)
				send_item(OP_CLEAR, SZ_W'($urandom_range(31)), TAG_W'($urandom));
			else
				send_item(OP_ALLOC, pick_size(), TAG_W'($urandom));
		end
		start <= 1'b0;

		@(posedge clk);
		while (pending != 0)
			@(posedge clk);
		repeat (300) @(posedge clk);
		if (errors == 0 && pending == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end

endmodule
